// ===== hw/rtl/nsad_pkg.sv =====
// ----------------------------------------------------------------------------
// nsad_pkg
// Shared types and constants of the 3x3 neighbourhood SAD block.
// ----------------------------------------------------------------------------
package nsad_pkg;

  localparam int NUM_SUMS   = 9;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 32;
  localparam int CODE_W     = 4;
  localparam int SIZE_W     = 13;
  localparam int CFG_ADDR_W = 4;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MASK_ENABLE  = 2'd2;
  localparam logic [1:0] REG_MASK_INDEX   = 2'd3;

  localparam logic [CODE_W-1:0] LAST_CODE = CODE_W'(NUM_SUMS - 1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic              mask_enable;
    pix_t              mask_index;
  } nsad_cfg_t;

  // One evaluated raster step, presented to the accumulator bank.
  typedef struct packed {
    logic valid;
    logic contrib;
    logic frame_end;
  } nsad_step_t;

endpackage

// ===== hw/rtl/nsad_ram.sv =====
// ----------------------------------------------------------------------------
// nsad_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module nsad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read of the address written in the same cycle returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/nsad_cfg.sv =====
// ----------------------------------------------------------------------------
// nsad_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module nsad_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [nsad_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready,
  output nsad_pkg::nsad_cfg_t                cfg
);

  import nsad_pkg::*;

  nsad_cfg_t   cfg_r;
  nsad_cfg_t   cfg_nxt;
  logic        wr_en;
  logic [1:0]  reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_pwdata[SIZE_W-1:0];
        REG_MASK_ENABLE:  cfg_nxt.mask_enable  = cfg_pwdata[0];
        REG_MASK_INDEX:   cfg_nxt.mask_index   = cfg_pwdata[PIX_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= SIZE_W'(64);
      cfg_r.frame_height <= SIZE_W'(64);
      cfg_r.mask_enable  <= 1'b0;
      cfg_r.mask_index   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  cfg_prdata = 32'(cfg_r.frame_width);
      REG_FRAME_HEIGHT: cfg_prdata = 32'(cfg_r.frame_height);
      REG_MASK_ENABLE:  cfg_prdata = 32'(cfg_r.mask_enable);
      REG_MASK_INDEX:   cfg_prdata = 32'(cfg_r.mask_index);
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/nsad_front.sv =====
// ----------------------------------------------------------------------------
// nsad_front
// Raster position, line memories and the 3x3 background window.
// ----------------------------------------------------------------------------
module nsad_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nsad_pkg::nsad_cfg_t         cfg,
  input  logic                        accept,
  input  nsad_pkg::pix_t              cur_pix,
  input  nsad_pkg::pix_t              bg_pix,
  input  nsad_pkg::pix_t              mask_pix,
  output logic                        end_now,
  output nsad_pkg::nsad_step_t        step,
  output nsad_pkg::pix_t [8:0]        window,
  output nsad_pkg::pix_t              held_cur
);

  import nsad_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [31:0]   fw, fh, xc, yc, xc_inc, yc_inc;
  logic [CW-1:0] xa;
  logic          par, col_last, row_last, interior;

  logic          s1_valid_r, s1_par_r, s1_inter_r, s1_end_r;
  pix_t          s1_bg_r;

  pix_t          bg0_rd, bg1_rd, top, mid;
  logic [2*PIX_W-1:0] cm_rd;
  pix_t          held_cur_r, held_mk_r;
  pix_t [8:0]    window_r, window_nxt;

  // Sizes are used clamped to [3, maximum].
  always_comb begin
    fw = 32'(cfg.frame_width);
    if (fw < 32'd3) begin
      fw = 32'd3;
    end else if (fw > 32'(MAX_WIDTH)) begin
      fw = 32'(MAX_WIDTH);
    end
    fh = 32'(cfg.frame_height);
    if (fh < 32'd3) begin
      fh = 32'd3;
    end else if (fh > 32'(MAX_HEIGHT)) begin
      fh = 32'(MAX_HEIGHT);
    end
  end

  // A position beyond a shrunken frame is taken as the last column or row.
  assign xc       = (32'(col_r) >= fw) ? fw - 32'd1 : 32'(col_r);
  assign yc       = (32'(row_r) >= fh) ? fh - 32'd1 : 32'(row_r);
  assign xc_inc   = xc + 32'd1;
  assign yc_inc   = yc + 32'd1;
  assign xa       = xc[CW-1:0];
  assign par      = yc[0];
  assign col_last = xc_inc >= fw;
  assign row_last = yc_inc >= fh;
  assign end_now  = col_last && row_last;
  assign interior = (xc >= 32'd2) && (yc >= 32'd2);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : yc_inc[RW-1:0];
      end else begin
        col_nxt = xc_inc[CW-1:0];
        row_nxt = yc[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_par_r   <= par;
      s1_inter_r <= interior;
      s1_end_r   <= end_now;
      s1_bg_r    <= bg_pix;
    end
  end

  // Background rows by row parity: the slot of this row's parity holds row y-2
  // and is overwritten with row y; the other slot holds row y-1.
  nsad_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bg_even (
    .clk   (clk),
    .we    (accept && !par),
    .waddr (xa),
    .wdata (bg_pix),
    .re    (accept),
    .raddr (xa),
    .rdata (bg0_rd)
  );

  nsad_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bg_odd (
    .clk   (clk),
    .we    (accept && par),
    .waddr (xa),
    .wdata (bg_pix),
    .re    (accept),
    .raddr (xa),
    .rdata (bg1_rd)
  );

  // Current and mask pixels share one line; the read of the old entry gives
  // the pixel one row up, held until the next transaction.
  nsad_ram #(.WIDTH(2 * PIX_W), .DEPTH(MAX_WIDTH)) u_cur_mask (
    .clk   (clk),
    .we    (accept),
    .waddr (xa),
    .wdata ({mask_pix, cur_pix}),
    .re    (accept),
    .raddr (xa),
    .rdata (cm_rd)
  );

  assign top = s1_par_r ? bg1_rd : bg0_rd;
  assign mid = s1_par_r ? bg0_rd : bg1_rd;

  always_comb begin
    window_nxt = window_r;
    for (int r = 0; r < 3; r++) begin
      window_nxt[r*3]     = window_r[r*3 + 1];
      window_nxt[r*3 + 1] = window_r[r*3 + 2];
    end
    window_nxt[2] = top;
    window_nxt[5] = mid;
    window_nxt[8] = s1_bg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (s1_valid_r) begin
      window_r <= window_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      held_cur_r <= cm_rd[PIX_W-1:0];
      held_mk_r  <= cm_rd[2*PIX_W-1:PIX_W];
    end
  end

  assign step.valid     = s1_valid_r;
  assign step.frame_end = s1_valid_r && s1_end_r;
  assign step.contrib   = s1_valid_r && s1_inter_r &&
                          (!cfg.mask_enable || (held_mk_r == cfg.mask_index));
  assign window         = window_nxt;
  assign held_cur       = held_cur_r;

  a_step_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(accept))
    else $error("step evaluated without a preceding input transaction");

endmodule

// ===== hw/rtl/nsad_accum.sv =====
// ----------------------------------------------------------------------------
// nsad_accum
// Nine saturating SAD accumulators and the result drain buffer.
// ----------------------------------------------------------------------------
module nsad_accum (
  input  logic                             clk,
  input  logic                             rst_n,
  input  nsad_pkg::nsad_step_t             step,
  input  nsad_pkg::pix_t [8:0]             window,
  input  nsad_pkg::pix_t                   held_cur,
  output logic                             busy,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [nsad_pkg::CODE_W-1:0]      out_code,
  output nsad_pkg::sum_t                   out_sum,
  output logic                             out_last
);

  import nsad_pkg::*;

  sum_t [NUM_SUMS-1:0] acc_r, acc_nxt, acc_add;
  sum_t [NUM_SUMS-1:0] buf_r;
  logic [CODE_W-1:0]   code_r;
  logic                busy_r;
  logic                pop;

  always_comb begin
    logic [SUM_W:0] total;
    pix_t           d;
    for (int k = 0; k < NUM_SUMS; k++) begin
      d = (held_cur > window[k]) ? held_cur - window[k] : window[k] - held_cur;
      total = {1'b0, acc_r[k]} + (SUM_W + 1)'(d);
      acc_add[k] = total[SUM_W] ? '1 : total[SUM_W-1:0];
    end
  end

  assign acc_nxt = step.contrib ? acc_add : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (step.frame_end) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign pop = busy_r && out_ready;

  // Sums leave from the bottom entry; the rest move down one place per pop.
  always_ff @(posedge clk) begin
    if (step.frame_end) begin
      buf_r <= acc_nxt;
    end else if (pop) begin
      for (int k = 0; k < NUM_SUMS - 1; k++) begin
        buf_r[k] <= buf_r[k + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      code_r <= '0;
    end else if (step.frame_end) begin
      busy_r <= 1'b1;
      code_r <= '0;
    end else if (pop) begin
      if (code_r == LAST_CODE) begin
        busy_r <= 1'b0;
        code_r <= '0;
      end else begin
        code_r <= code_r + 1'b1;
      end
    end
  end

  assign busy      = busy_r;
  assign out_valid = busy_r;
  assign out_code  = code_r;
  assign out_sum   = buf_r[0];
  assign out_last  = (code_r == LAST_CODE);

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    step.frame_end |-> !busy_r)
    else $error("frame sums loaded while previous sums are still draining");

  a_drain_starts: assert property (@(posedge clk) disable iff (!rst_n)
    step.frame_end |=> (busy_r && (code_r == '0)))
    else $error("drain did not start at offset zero after frame end");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    code_r <= LAST_CODE)
    else $error("offset code beyond the last sum");

  a_idle_code: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (code_r == '0))
    else $error("offset code not cleared while idle");

endmodule

// ===== hw/rtl/neighbourhood_sad_3x3.sv =====
// ----------------------------------------------------------------------------
// neighbourhood_sad_3x3
// 3x3 neighbourhood sum of absolute differences between two images.
// ----------------------------------------------------------------------------
// One pixel triple (current, background, mask) is taken per clock cycle in
// raster order. Two background rows and one row of current and mask pixels
// live in single-port-read RAMs of MAX_WIDTH entries with a registered read
// port; the window and the nine accumulators follow in the cycle after the
// input transaction. After the frame's last pixel the nine sums are loaded
// into the drain buffer at the frame-end step and then appear on the output,
// one per output transaction, offset 0 first and tlast on offset 8, while the
// next frame already streams in. Input is held off only when a frame ends
// while the previous frame's sums are not yet all taken. With a free output
// side the rate stays at one pixel per cycle, except for 3x3 frames sent back
// to back: the drain of a frame's nine sums is not yet done when the last
// pixel of the following 3x3 frame arrives, so that pixel waits.
// Line memory contents are not cleared after reset; no pixel of an earlier
// frame ever reaches a sum.
module neighbourhood_sad_3x3 #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [7:0] current_pixel, [15:8] background_pixel, [23:16] mask_pixel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,
  // out_tdata: [3:0] offset_code, [35:4] diff_sum, [39:36] zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [39:0]                      out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [nsad_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  import nsad_pkg::*;

  nsad_cfg_t         cfg;
  nsad_step_t        step;
  pix_t [8:0]        window;
  pix_t              held_cur;
  logic              end_now, busy, accept;
  logic [CODE_W-1:0] out_code;
  sum_t              out_sum;

  assign in_tready = !(end_now && busy);
  assign accept    = in_tvalid && in_tready;

  nsad_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  nsad_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .accept   (accept),
    .cur_pix  (in_tdata[7:0]),
    .bg_pix   (in_tdata[15:8]),
    .mask_pix (in_tdata[23:16]),
    .end_now  (end_now),
    .step     (step),
    .window   (window),
    .held_cur (held_cur)
  );

  nsad_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .window    (window),
    .held_cur  (held_cur),
    .busy      (busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_code  (out_code),
    .out_sum   (out_sum),
    .out_last  (out_tlast)
  );

  assign out_tdata = {4'b0000, out_sum, out_code};

endmodule
